/* rtl/assert_macros.svh */
// Assertion macros shared by the grid corner indexer RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/gcci_pkg.sv */
// Package for the grid corner cell indexer: widths, register codes, payload types.
// No dependencies; used by the channel interfaces and the top level.
package gcci_pkg;

   localparam int AXIS_BITS   = 8;
   localparam int FRAC_BITS   = 16;

   localparam int POS_W       = 32;
   localparam int POS_FRAC_W  = 16;
   localparam int IDX_W       = 25;
   localparam int RECIP_W     = 21;
   localparam int DIM_FIELD_W = 9;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 63;
   localparam int INV_W       = 3 * RECIP_W;
   localparam int DIMS_W      = 3 * DIM_FIELD_W;

   // Product of offset and reciprocal, and its split into cell and fraction.
   localparam int PROD_W      = POS_W + RECIP_W;
   localparam int FRAC_TOT_W  = POS_FRAC_W + FRAC_BITS;
   localparam int CELL_W      = PROD_W - FRAC_TOT_W;
   localparam int HALF_BIT    = FRAC_TOT_W - 1;

   localparam int DIM_W       = AXIS_BITS + 1;
   localparam int DIM_CAP     = 1 << AXIS_BITS;
   localparam int FLD_EXT_W   = (DIM_FIELD_W > DIM_W) ? DIM_FIELD_W : DIM_W;
   localparam int DZDY_W      = 2 * DIM_W;
   localparam int XP_W        = AXIS_BITS + DZDY_W;
   localparam int ZP_W        = AXIS_BITS + DIM_W;
   localparam int SUM_W       = XP_W + 1;
   localparam int ACC_W       = (SUM_W > IDX_W) ? SUM_W : IDX_W;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Z = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_X = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Y = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Z = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_INV   = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_DIMS  = CSR_IDX_W'(7);

   localparam logic [IDX_W-1:0] IDX_OFF_GRID = '1;

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic signed [IDX_W-1:0] idx_type;
   typedef logic [CSR_IDX_W-1:0]    csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]   csr_data_type;

endpackage

/* rtl/gcci_if.sv */
// Valid/ready channel interfaces for positions, corner indices and register writes.
// Depends on gcci_pkg for payload types.
interface gcci_req_if;
   import gcci_pkg::*;
   logic    valid;
   logic    ready;
   pos_type pos_x;
   pos_type pos_y;
   pos_type pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface gcci_rsp_if;
   import gcci_pkg::*;
   logic    valid;
   logic    ready;
   idx_type idx_hi_hi_hi;
   idx_type idx_hi_hi_lo;
   idx_type idx_hi_lo_hi;
   idx_type idx_hi_lo_lo;
   idx_type idx_lo_hi_hi;
   idx_type idx_lo_hi_lo;
   idx_type idx_lo_lo_hi;
   idx_type idx_lo_lo_lo;
   modport source (output valid, idx_hi_hi_hi, idx_hi_hi_lo, idx_hi_lo_hi, idx_hi_lo_lo,
                   idx_lo_hi_hi, idx_lo_hi_lo, idx_lo_lo_hi, idx_lo_lo_lo, input ready);
   modport sink   (input valid, idx_hi_hi_hi, idx_hi_hi_lo, idx_hi_lo_hi, idx_hi_lo_lo,
                   idx_lo_hi_hi, idx_lo_hi_lo, idx_lo_lo_hi, idx_lo_lo_lo, output ready);
endinterface

interface gcci_csr_if;
   import gcci_pkg::*;
   logic         valid;
   logic         ready;
   csr_idx_type  addr;
   csr_data_type wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

/* rtl/grid_corner_cell_indexer_unit.sv */
// Top level of the grid corner cell indexer: five-stage pipeline and config registers.
// Depends on gcci_pkg, the channel interfaces in gcci_if.sv and assert_macros.svh.
//
//   channel   dir   payload                              item moves when
//   req_ch    in    pos_x, pos_y, pos_z                  valid && ready
//   rsp_ch    out   eight 25-bit corner indices          valid && ready
//   csr_ch    in    addr, wdata                          valid && ready (always ready)
//
// One item per cycle while the enable below is high; each item passes the stages in order.
// The stages are: box test and offset, reciprocal multiply, base cell and bounds,
// index partial products, final sums. One enable moves all stages together; it
// is low only while a result waits in the output register and rsp_ch is not ready.
// Reset clears the valid bits and sets every config register to zero.
`include "assert_macros.svh"

module grid_corner_cell_indexer_unit (
   input logic clock,
   input logic reset,
   gcci_req_if.sink   req_ch,
   gcci_rsp_if.source rsp_ch,
   gcci_csr_if.sink   csr_ch
);
   import gcci_pkg::*;

   // Configuration registers.
   pos_type            min_ff [3];
   pos_type            max_ff [3];
   logic [INV_W-1:0]   inv_ff;
   logic [DIMS_W-1:0]  dims_ff;

   // Derived from config, refreshed every cycle.
   logic [DIM_W-1:0]   dim_in [3];
   logic [DZDY_W-1:0]  dzdy_ff;
   logic [DIM_W-1:0]   dy_ff;

   logic               advance;

   // Stage 1: offset and box test.
   logic               v1_ff;
   logic [POS_W-1:0]   d_in  [3];
   logic [POS_W-1:0]   d_ff  [3];
   logic               inb1_in;
   logic               inb1_ff;

   // Stage 2: cell and half flag.
   logic               v2_ff;
   logic [PROD_W-1:0]  prod_in [3];
   logic [CELL_W-1:0]  cell_ff [3];
   logic               above_ff [3];
   logic               inb2_ff;

   // Stage 3: corner coordinates and on-grid flags.
   logic               v3_ff;
   logic [CELL_W:0]    base_in [3];
   logic [CELL_W+1:0]  hi_in   [3];
   logic [AXIS_BITS-1:0] lo_c_in [3];
   logic [AXIS_BITS-1:0] hi_c_in [3];
   logic               lo_ok_in [3];
   logic               hi_ok_in [3];
   logic [AXIS_BITS-1:0] crd_ff [3][2];
   logic               ok3_ff  [3][2];
   logic               inb3_ff;

   // Stage 4: partial products.
   logic               v4_ff;
   logic [XP_W-1:0]    xp_ff [2];
   logic [ZP_W-1:0]    zp_ff [2];
   logic [AXIS_BITS-1:0] y_ff [2];
   logic               ok4_ff [3][2];
   logic               inb4_ff;

   // Stage 5: output register, corner k in result order.
   logic               v5_ff;
   logic [ACC_W-1:0]   sum_in [8];
   idx_type            out_in [8];
   idx_type            out_ff [8];

   assign advance      = !v5_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= '0;
         end
         inv_ff  <= '0;
         dims_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            REG_MIN_X: min_ff[0] <= csr_ch.wdata[POS_W-1:0];
            REG_MIN_Y: min_ff[1] <= csr_ch.wdata[POS_W-1:0];
            REG_MIN_Z: min_ff[2] <= csr_ch.wdata[POS_W-1:0];
            REG_MAX_X: max_ff[0] <= csr_ch.wdata[POS_W-1:0];
            REG_MAX_Y: max_ff[1] <= csr_ch.wdata[POS_W-1:0];
            REG_MAX_Z: max_ff[2] <= csr_ch.wdata[POS_W-1:0];
            REG_INV:   inv_ff    <= csr_ch.wdata[INV_W-1:0];
            REG_DIMS:  dims_ff   <= csr_ch.wdata[DIMS_W-1:0];
            default:   ;
         endcase
      end
   end

   // Dimensions above the grid limit saturate to it.
   always_comb begin
      logic [FLD_EXT_W-1:0] fld;
      for (int a = 0; a < 3; a++) begin
         fld = FLD_EXT_W'(dims_ff[DIM_FIELD_W*a +: DIM_FIELD_W]);
         dim_in[a] = (fld > FLD_EXT_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : DIM_W'(fld);
      end
   end

   always_ff @(posedge clock) begin
      dzdy_ff <= DZDY_W'(dim_in[2]) * DZDY_W'(dim_in[1]);
      dy_ff   <= dim_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stage 1. Inside the box the offset is below 2^32, so the low word is exact.
   always_comb begin
      d_in[0] = req_ch.pos_x - min_ff[0];
      d_in[1] = req_ch.pos_y - min_ff[1];
      d_in[2] = req_ch.pos_z - min_ff[2];
      inb1_in = (req_ch.pos_x >= min_ff[0]) && (req_ch.pos_x < max_ff[0]) &&
                (req_ch.pos_y >= min_ff[1]) && (req_ch.pos_y < max_ff[1]) &&
                (req_ch.pos_z >= min_ff[2]) && (req_ch.pos_z < max_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff    <= d_in;
         inb1_ff <= inb1_in;
      end
   end

   // Stage 2. The fraction is above one half when its top bit is set and any
   // lower bit is set.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod_in[a] = PROD_W'(d_ff[a]) * PROD_W'(inv_ff[RECIP_W*a +: RECIP_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            cell_ff[a]  <= prod_in[a][PROD_W-1:FRAC_TOT_W];
            above_ff[a] <= prod_in[a][HALF_BIT] && (|prod_in[a][HALF_BIT-1:0]);
         end
         inb2_ff <= inb1_ff;
      end
   end

   // Stage 3. Base cell runs from -1 upward; base+1 needs one more bit.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         base_in[a]  = above_ff[a] ? {1'b0, cell_ff[a]} : ({1'b0, cell_ff[a]} - 1'b1);
         hi_in[a]    = {base_in[a][CELL_W], base_in[a]} + 1'b1;
         lo_ok_in[a] = !base_in[a][CELL_W] &&
                       (base_in[a][CELL_W-1:0] < CELL_W'(dim_in[a]));
         hi_ok_in[a] = !hi_in[a][CELL_W+1] &&
                       (hi_in[a][CELL_W:0] < (CELL_W+1)'(dim_in[a]));
         lo_c_in[a]  = base_in[a][AXIS_BITS-1:0];
         hi_c_in[a]  = hi_in[a][AXIS_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            crd_ff[a][0] <= lo_c_in[a];
            crd_ff[a][1] <= hi_c_in[a];
            ok3_ff[a][0] <= lo_ok_in[a];
            ok3_ff[a][1] <= hi_ok_in[a];
         end
         inb3_ff <= inb2_ff;
      end
   end

   // Stage 4. Axis order in the index is x major, then z, then y.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 2; j++) begin
            xp_ff[j] <= XP_W'(crd_ff[0][j]) * XP_W'(dzdy_ff);
            zp_ff[j] <= ZP_W'(crd_ff[2][j]) * ZP_W'(dy_ff);
            y_ff[j]  <= crd_ff[1][j];
         end
         ok4_ff  <= ok3_ff;
         inb4_ff <= inb3_ff;
      end
   end

   // Stage 5. A clear bit of k selects the upper corner on that axis.
   always_comb begin
      logic jx, jy, jz;
      for (int k = 0; k < 8; k++) begin
         jx = !k[2];
         jy = !k[1];
         jz = !k[0];
         sum_in[k] = ACC_W'(xp_ff[jx]) + ACC_W'(zp_ff[jz]) + ACC_W'(y_ff[jy]);
         out_in[k] = (inb4_ff && ok4_ff[0][jx] && ok4_ff[1][jy] && ok4_ff[2][jz]) ?
                     sum_in[k][IDX_W-1:0] : IDX_OFF_GRID;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid        = v5_ff;
   assign rsp_ch.idx_hi_hi_hi = out_ff[0];
   assign rsp_ch.idx_hi_hi_lo = out_ff[1];
   assign rsp_ch.idx_hi_lo_hi = out_ff[2];
   assign rsp_ch.idx_hi_lo_lo = out_ff[3];
   assign rsp_ch.idx_lo_hi_hi = out_ff[4];
   assign rsp_ch.idx_lo_hi_lo = out_ff[5];
   assign rsp_ch.idx_lo_lo_hi = out_ff[6];
   assign rsp_ch.idx_lo_lo_lo = out_ff[7];

   // The input side only stalls behind a result that is waiting.
   `ASSERT_IMPLIES(a_stall_needs_result, clock, reset, !req_ch.ready, rsp_ch.valid)

   // A position outside the box gives off-grid for every corner; the check samples corners 0, 3, 5 and 7.
   `ASSERT_NEXT(a_out_of_box, clock, reset, advance && v4_ff && !inb4_ff,
      rsp_ch.valid && (out_ff[0] == IDX_OFF_GRID) && (out_ff[3] == IDX_OFF_GRID) &&
      (out_ff[5] == IDX_OFF_GRID) && (out_ff[7] == IDX_OFF_GRID))

   // An axis with no cells leaves every corner off the grid; the check samples corners 0, 2, 4 and 7.
   `ASSERT_IMPLIES(a_zero_dim, clock, reset,
      rsp_ch.valid && ((dim_in[0] == '0) || (dim_in[1] == '0) || (dim_in[2] == '0)),
      (out_ff[0] == IDX_OFF_GRID) && (out_ff[2] == IDX_OFF_GRID) &&
      (out_ff[4] == IDX_OFF_GRID) && (out_ff[7] == IDX_OFF_GRID))

endmodule
